// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    // Input operation codes
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Queue entry between front and back
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } item_t;

    // Back-end state machine
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[r];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// Input stage and word queue: decouples the stream input from the core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire sha_pkg::item_t in_item,
    output logic               q_valid,
    input  wire logic          q_pop,
    output sha_pkg::item_t     q_item
);

    sha_pkg::item_t mem [0:sha_pkg::QUEUE_DEPTH-1];
    logic [sha_pkg::QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [sha_pkg::QUEUE_AW:0]   cnt_reg;
    logic push;

    assign in_ready = (cnt_reg != (sha_pkg::QUEUE_AW+1)'(sha_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem[rd_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (sha_pkg::QUEUE_AW+1)'(push)
                               - (sha_pkg::QUEUE_AW+1)'(q_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// Block buffer, padding, one-round-per-cycle compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire sha_pkg::item_t q_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        out_word,
    output logic [2:0]         out_index,
    output logic               out_last
);

    sha_pkg::state_t state_reg, state_next;

    logic [31:0] w_reg [0:15];     // 16-word schedule window, also block buffer
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [5:0]  pos_reg;
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;          // current compression is part of finish
    logic        two_reg;          // a second pad block still follows
    logic [2:0]  oidx_reg;

    // Round datapath
    logic [31:0] s0, s1, wnew, big0, big1, ch, maj, t1, t2;
    logic [63:0] total;

    always_comb
    begin
        s0   = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        big1 = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
             ^ sha_pkg::rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0 = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
             ^ sha_pkg::rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + big1 + ch + sha_pkg::round_k(rnd_reg) + w_reg[0];
        t2   = big0 + maj;
        total = bits_reg + {55'd0, pos_reg, 3'd0};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == sha_pkg::OP_FINISH)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                    else if (pos_reg == 6'd63)
                    begin
                        state_next = sha_pkg::ST_COMP;
                    end
                end
            end
            sha_pkg::ST_PAD:  state_next = sha_pkg::ST_COMP;
            sha_pkg::ST_COMP:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD:
            begin
                if (two_reg)
                begin
                    state_next = sha_pkg::ST_COMP;
                end
                else if (fin_reg)
                begin
                    state_next = sha_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (out_ready && oidx_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        q_pop     = (state_reg == sha_pkg::ST_IDLE) && q_valid;
        out_valid = (state_reg == sha_pkg::ST_EMIT);
        out_word  = h_reg[oidx_reg];
        out_index = oidx_reg;
        out_last  = (oidx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::init_h(3'(i));
            end
            pos_reg  <= '0;
            bits_reg <= '0;
            rnd_reg  <= '0;
            fin_reg  <= 1'b0;
            two_reg  <= 1'b0;
            oidx_reg <= '0;
        end
        else
        begin
            case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    if (q_valid && q_item.op == sha_pkg::OP_ABSORB)
                    begin
                        pos_reg <= pos_reg + 6'd1;
                        fin_reg <= 1'b0;
                        if (pos_reg == 6'd63)
                        begin
                            bits_reg <= bits_reg + 64'd512;
                            rnd_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= h_reg[i];
                            end
                        end
                    end
                    else if (q_valid)
                    begin
                        fin_reg <= 1'b1;
                    end
                end
                sha_pkg::ST_PAD:
                begin
                    two_reg <= (pos_reg >= 6'd56);
                    rnd_reg <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
                sha_pkg::ST_COMP:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                sha_pkg::ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                        v_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    rnd_reg <= '0;
                    two_reg <= 1'b0;
                    oidx_reg <= '0;
                end
                sha_pkg::ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::init_h(3'(i));
                            end
                            pos_reg  <= '0;
                            bits_reg <= '0;
                            fin_reg  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Schedule window: byte writes, padding, shift during rounds
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (q_valid && q_item.op == sha_pkg::OP_ABSORB)
                begin
                    case (pos_reg[1:0])
                        2'd0: w_reg[pos_reg[5:2]][31:24] <= q_item.data;
                        2'd1: w_reg[pos_reg[5:2]][23:16] <= q_item.data;
                        2'd2: w_reg[pos_reg[5:2]][15:8]  <= q_item.data;
                        default: w_reg[pos_reg[5:2]][7:0] <= q_item.data;
                    endcase
                end
            end
            sha_pkg::ST_PAD:
            begin
                // 0x80 marker, zero fill, length in last two words if room
                for (int i = 0; i < 16; i++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if (6'(4*i + b) == pos_reg)
                        begin
                            w_reg[i][31-8*b -: 8] <= 8'h80;
                        end
                        else if (6'(4*i + b) > pos_reg)
                        begin
                            w_reg[i][31-8*b -: 8] <= 8'h00;
                        end
                    end
                end
                if (pos_reg < 6'd56)
                begin
                    w_reg[14] <= total[63:32];
                    w_reg[15] <= total[31:0];
                end
            end
            sha_pkg::ST_COMP:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= wnew;
            end
            sha_pkg::ST_ADD:
            begin
                // second pad block: zeros then length
                if (two_reg)
                begin
                    for (int i = 0; i < 14; i++)
                    begin
                        w_reg[i] <= '0;
                    end
                    w_reg[14] <= total[63:32];
                    w_reg[15] <= total[31:0];
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream; finish emits eight digest words.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                               tuser
// s_axis    in   [7:0] message_byte                  [0] operation (1 = finish)
// m_axis    out  [31:0] digest_word, [34:32] index   -, tlast = last_word
//
// Bytes enter a four-word queue at one per cycle while it has room.
// The last byte of a full block holds the core through the compression rounds and the final add.
// Finish: padding, one or two blocks of rounds, then eight output words.
// Reset restores the initial hash values; output stalls hold the core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  wire logic        s_axis_tuser,   // [0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_axis_tlast
);

    sha_pkg::item_t in_item, q_item;
    logic q_valid, q_pop;
    logic [31:0] word;
    logic [2:0]  idx;

    assign in_item.op   = s_axis_tuser;
    assign in_item.data = s_axis_tdata;

    sha_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (word),
        .out_index (idx),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, idx, word};

endmodule

`default_nettype wire

// ===== bench/sha256_byte_stream_hasher_tb.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_tb
// Streams messages into the hasher and checks every digest word against a
// behavioral SHA-256 kept inside the bench, with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    sha256_byte_stream_hasher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    typedef struct {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic        has_digest;   // digest known at a glance
        logic [31:0] digest0;      // word 0 of that digest
    } stim_row_t;

    localparam logic [31:0] H_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] K_ROUND [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // Bench copy of the hasher state
    logic [31:0] hash_state [0:7];
    logic [7:0]  blk_bytes [0:63];
    logic [5:0]  fill_count;
    logic [63:0] done_bits;

    digest_word_t digest_q[$];
    int           errors;
    int           mismatches;
    bit           stim_done;

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of blk_bytes into hash_state
    task automatic compress_blk();
        logic [31:0] w [0:63];
        logic [31:0] v [0:7];
        logic [31:0] t1, t2, s0, s1;
        for (int r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        for (int r = 16; r < 64; r++)
        begin
            s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = s1 + w[r-7] + s0 + w[r-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = H_INIT[i];
        fill_count = '0;
        done_bits  = '0;
    endtask

    // Absorb a byte or pad and queue the eight digest words
    task automatic hash_word_in(logic op, logic [7:0] data);
        logic [63:0] total;
        if (op == sha_pkg::OP_ABSORB)
        begin
            blk_bytes[fill_count] = data;
            if (fill_count == 6'd63)
            begin
                compress_blk();
                done_bits += 64'd512;
            end
            fill_count = fill_count + 6'd1;
        end
        else
        begin
            total = done_bits + {fill_count, 3'b000};
            blk_bytes[fill_count] = 8'h80;
            for (int k = fill_count + 1; k < 64; k++)
                blk_bytes[k] = 8'h00;
            if (fill_count >= 6'd56)
            begin
                compress_blk();
                for (int k = 0; k < 56; k++)
                    blk_bytes[k] = 8'h00;
            end
            for (int k = 0; k < 8; k++)
                blk_bytes[56+k] = total[63-8*k -: 8];
            compress_blk();
            for (int k = 0; k < 8; k++)
                digest_q.push_back('{hash_state[k], 3'(k), k == 7});
            restart_hash();
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Send one word after a random gap; valid stays high across zero gaps
    task automatic send_word(logic op, logic [7:0] data);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hash_word_in(op, data);
    endtask

    // Directed rows: empty, "abc", extreme byte values, repeated empty
    stim_row_t dir_rows[$];

    task automatic add_row(logic op, logic [7:0] d, logic has, logic [31:0] d0);
        dir_rows.push_back('{op, d, has, d0});
    endtask

    task automatic send_random_msg(int len);
        for (int i = 0; i < len; i++)
        begin
            // occasional early finish as noise
            if ($urandom_range(0, 40) == 0)
                send_word(sha_pkg::OP_FINISH, 8'($urandom));
            else
                send_word(sha_pkg::OP_ABSORB, 8'($urandom));
        end
        send_word(sha_pkg::OP_FINISH, 8'($urandom));
    endtask

    // Stimulus
    initial
    begin
        int sent;
        int lens [0:4];
        errors        = 0;
        mismatches    = 0;
        stim_done     = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        restart_hash();
        for (int i = 0; i < 64; i++)
            blk_bytes[i] = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(sha_pkg::OP_FINISH, 8'hff, 1'b1, 32'he3b0c442);   // empty message
        add_row(sha_pkg::OP_ABSORB, 8'h61, 1'b0, '0);
        add_row(sha_pkg::OP_ABSORB, 8'h62, 1'b0, '0);
        add_row(sha_pkg::OP_ABSORB, 8'h63, 1'b0, '0);
        add_row(sha_pkg::OP_FINISH, 8'h00, 1'b1, 32'hba7816bf);   // "abc"
        add_row(sha_pkg::OP_ABSORB, 8'h00, 1'b0, '0);
        add_row(sha_pkg::OP_ABSORB, 8'hff, 1'b0, '0);
        add_row(sha_pkg::OP_ABSORB, 8'h55, 1'b0, '0);
        add_row(sha_pkg::OP_ABSORB, 8'haa, 1'b0, '0);
        add_row(sha_pkg::OP_FINISH, 8'h00, 1'b0, '0);
        add_row(sha_pkg::OP_FINISH, 8'h00, 1'b1, 32'he3b0c442);   // restart leaves empty

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].op, dir_rows[i].data);
            if (dir_rows[i].has_digest && digest_q.size() >= 8
                && digest_q[digest_q.size()-8].digest != dir_rows[i].digest0)
            begin
                errors++;
                $display("bench digest row %0d: %h", i, digest_q[digest_q.size()-8].digest);
            end
        end
        sent = dir_rows.size();

        // Lengths around the one- and two-block padding boundaries
        lens = '{55, 56, 63, 64, 120};
        foreach (lens[i])
        begin
            send_random_msg(lens[i]);
            sent += lens[i] + 1;
        end
        // Random messages, mostly short
        while (sent < 420)
        begin
            int len;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 20);
            send_random_msg(len);
            sent += len + 1;
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Output side: random stalls, compare against the oldest expected word
    initial
    begin
        digest_word_t exp_w;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected digest word %h", m_axis_tdata);
                end
                else
                begin
                    exp_w = digest_q.pop_front();
                    if (m_axis_tdata[31:0] != exp_w.digest || m_axis_tdata[34:32] != exp_w.index
                        || m_axis_tlast != exp_w.last)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_w.digest, exp_w.index, exp_w.last,
                                     m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 2) != 0) ? 1'b1 : ($urandom_range(0, 4) == 0);
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sha256_byte_stream_hasher.f =====
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_core.sv
rtl/sha256_byte_stream_hasher.sv
bench/sha256_byte_stream_hasher_tb.sv
